[design/etc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc_pkg
// Shared types and constants of the event timer block.
// ----------------------------------------------------------------------------
package etc_pkg;

    localparam int NUM_TIMERS = 3;

    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 10;
    localparam int PERIOD_FS_W = 27;
    localparam int REV_W       = 8;
    localparam int PCAP_W      = 3;

    // APB register map of the static configuration
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] CFG_PERIOD_FS = 2'd0;
    localparam logic [1:0] CFG_REVISION  = 2'd1;
    localparam logic [1:0] CFG_PCAP_MASK = 2'd2;

    // Beat operations
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Register offsets
    localparam logic [ADDR_W-1:0] ADDR_CAPS       = 10'h000;
    localparam logic [ADDR_W-1:0] ADDR_CONFIG     = 10'h010;
    localparam logic [ADDR_W-1:0] ADDR_STATUS     = 10'h020;
    localparam logic [ADDR_W-1:0] ADDR_COUNTER    = 10'h0F0;
    localparam logic [4:0]        TIMER_BASE_SLOT = 5'd8;
    localparam logic [1:0]        OFF_TMR_CFG     = 2'd0;
    localparam logic [1:0]        OFF_TMR_CMP     = 2'd1;

    // Timer config register bits
    localparam int TCFG_INT_EN   = 2;
    localparam int TCFG_PERIODIC = 3;
    localparam int TCFG_PER_CAP  = 4;
    localparam int TCFG_SIZE_CAP = 5;
    localparam int TCFG_VAL_SET  = 6;

    typedef struct packed {
        logic              wr_cfg;
        logic              wr_cmp;
        logic              tick;
        logic              cap;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] count_new;
    } t_tmr_ctl;

    typedef struct packed {
        logic              match;
        logic              int_en_nx;
        logic              int_en;
        logic              periodic;
        logic [DATA_W-1:0] comparator;
    } t_tmr_stat;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        logic [NUM_TIMERS-1:0] timer_irq;
        logic                  legacy_irq0;
        logic                  legacy_irq8;
    } t_result;

endpackage

[design/etc_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc_timer
// One comparator channel: flags, comparator and period with match detect.
// ----------------------------------------------------------------------------
module etc_timer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  etc_pkg::t_tmr_ctl i_ctl,
    output etc_pkg::t_tmr_stat o_stat
);

    logic                       r_int_en, n_int_en;
    logic                       r_periodic, n_periodic;
    logic                       r_val_set, n_val_set;
    logic [etc_pkg::DATA_W-1:0] r_comparator, n_comparator;
    logic [etc_pkg::DATA_W-1:0] r_period, n_period;
    logic                       match;

    assign match = i_ctl.tick && (i_ctl.count_new == r_comparator);

    always_comb begin
        n_int_en     = r_int_en;
        n_periodic   = r_periodic;
        n_val_set    = r_val_set;
        n_comparator = r_comparator;
        n_period     = r_period;
        if (i_ctl.wr_cfg) begin
            n_int_en   = i_ctl.data[etc_pkg::TCFG_INT_EN];
            n_periodic = i_ctl.data[etc_pkg::TCFG_PERIODIC] & i_ctl.cap;
            n_val_set  = i_ctl.data[etc_pkg::TCFG_VAL_SET];
        end else if (i_ctl.wr_cmp) begin
            if (!r_periodic || r_val_set) begin
                n_comparator = i_ctl.data;
            end
            n_period  = i_ctl.data;
            n_val_set = 1'b0;
        end else if (match && r_periodic) begin
            n_comparator = r_comparator + r_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_en     <= 1'b0;
            r_periodic   <= 1'b0;
            r_val_set    <= 1'b0;
            r_comparator <= '1;
            r_period     <= '0;
        end else begin
            r_int_en     <= n_int_en;
            r_periodic   <= n_periodic;
            r_val_set    <= n_val_set;
            r_comparator <= n_comparator;
            r_period     <= n_period;
        end
    end

    assign o_stat.match      = match;
    assign o_stat.int_en_nx  = n_int_en;
    assign o_stat.int_en     = r_int_en;
    assign o_stat.periodic   = r_periodic;
    assign o_stat.comparator = r_comparator;

endmodule

[design/event_timer_comparators_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_timer_comparators_top
// Event timer: main counter, per-timer comparators, status and irq lines.
// ----------------------------------------------------------------------------
// An accepted beat's result is registered in the output or the skid entry.
// Throughput: 1 beat per cycle when not stalled; state is updated on accept.
// Output register plus skid entry; o_in_stall is registered skid occupancy.
// Reset (synchronous, i_rst_n low): counter halted at zero, comparators all
// ones, periods, flags and status zero, static registers to defaults.
module event_timer_comparators_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [etc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [etc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [etc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // access / tick channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_operation,
    input  logic [etc_pkg::ADDR_W-1:0]         i_address,
    input  logic [etc_pkg::DATA_W-1:0]         i_write_data,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [etc_pkg::DATA_W-1:0]         o_read_data,
    output logic [etc_pkg::NUM_TIMERS-1:0]     o_timer_irq,
    output logic                               o_legacy_irq0,
    output logic                               o_legacy_irq8
);

    localparam int NT = etc_pkg::NUM_TIMERS;

    // static configuration
    logic [etc_pkg::PERIOD_FS_W-1:0] r_period_fs;
    logic [etc_pkg::REV_W-1:0]       r_revision;
    logic [etc_pkg::PCAP_W-1:0]      r_cap_mask;
    logic                            cfg_wr;

    // timer state
    logic                       r_global, n_global;
    logic                       r_legacy, n_legacy;
    logic [etc_pkg::DATA_W-1:0] r_count, n_count;
    logic [NT-1:0]              r_status, n_status;

    // result buffering
    etc_pkg::t_result r_out, r_skid, res;
    logic             r_out_valid, r_skid_valid;

    logic                       accept, out_take;
    logic                       is_read, is_write, tick_en;
    logic                       sel_config, sel_status, sel_counter, sel_caps;
    logic [4:0]                 t_idx;
    logic                       tmr_sel;
    logic [1:0]                 t_off;
    logic [etc_pkg::DATA_W-1:0] count_inc;
    logic [etc_pkg::DATA_W-1:0] caps;
    logic [etc_pkg::DATA_W-1:0] rd;
    logic [NT-1:0]              tmr_match, int_en_nx, lines;

    etc_pkg::t_tmr_ctl          tmr_ctl  [NT];
    etc_pkg::t_tmr_stat         tmr_stat [NT];
    logic [etc_pkg::DATA_W-1:0] tmr_rd   [NT];

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_fs <= etc_pkg::PERIOD_FS_W'(69841279);
            r_revision  <= etc_pkg::REV_W'(1);
            r_cap_mask  <= '1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                etc_pkg::CFG_PERIOD_FS: r_period_fs <= pwdata[etc_pkg::PERIOD_FS_W-1:0];
                etc_pkg::CFG_REVISION:  r_revision  <= pwdata[etc_pkg::REV_W-1:0];
                etc_pkg::CFG_PCAP_MASK: r_cap_mask  <= pwdata[etc_pkg::PCAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            etc_pkg::CFG_PERIOD_FS: prdata = etc_pkg::APB_DATA_W'(r_period_fs);
            etc_pkg::CFG_REVISION:  prdata = etc_pkg::APB_DATA_W'(r_revision);
            etc_pkg::CFG_PCAP_MASK: prdata = etc_pkg::APB_DATA_W'(r_cap_mask);
            default:                prdata = '0;
        endcase
    end

    // ---------------- decode ----------------
    assign accept   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    assign is_read  = accept && (i_operation == etc_pkg::OP_READ);
    assign is_write = accept && (i_operation == etc_pkg::OP_WRITE);
    assign tick_en  = accept && (i_operation == etc_pkg::OP_TICK) && r_global;

    assign sel_caps    = i_address[9:3] == etc_pkg::ADDR_CAPS[9:3];
    assign sel_config  = i_address[9:3] == etc_pkg::ADDR_CONFIG[9:3];
    assign sel_status  = i_address[9:3] == etc_pkg::ADDR_STATUS[9:3];
    assign sel_counter = i_address[9:3] == etc_pkg::ADDR_COUNTER[9:3];

    assign t_idx   = i_address[9:5] - etc_pkg::TIMER_BASE_SLOT;
    assign t_off   = i_address[4:3];
    assign tmr_sel = (i_address[9:8] != 2'b00) && (t_idx < 5'(NT));

    assign count_inc = r_count + etc_pkg::DATA_W'(1);

    // ---------------- timers ----------------
    for (genvar n = 0; n < NT; n++) begin : g_tmr
        logic sel_n;
        assign sel_n = tmr_sel && (t_idx == 5'(n));

        assign tmr_ctl[n].wr_cfg    = is_write && sel_n && (t_off == etc_pkg::OFF_TMR_CFG);
        assign tmr_ctl[n].wr_cmp    = is_write && sel_n && (t_off == etc_pkg::OFF_TMR_CMP);
        assign tmr_ctl[n].tick      = tick_en;
        assign tmr_ctl[n].cap       = r_cap_mask[n];
        assign tmr_ctl[n].data      = i_write_data;
        assign tmr_ctl[n].count_new = count_inc;

        etc_timer u_timer (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (tmr_ctl[n]),
            .o_stat  (tmr_stat[n])
        );

        assign tmr_match[n] = tmr_stat[n].match;
        assign int_en_nx[n] = tmr_stat[n].int_en_nx;

        always_comb begin
            tmr_rd[n] = '0;
            if (sel_n) begin
                if (t_off == etc_pkg::OFF_TMR_CFG) begin
                    tmr_rd[n][etc_pkg::TCFG_INT_EN]   = tmr_stat[n].int_en;
                    tmr_rd[n][etc_pkg::TCFG_PERIODIC] = tmr_stat[n].periodic;
                    tmr_rd[n][etc_pkg::TCFG_PER_CAP]  = r_cap_mask[n];
                    tmr_rd[n][etc_pkg::TCFG_SIZE_CAP] = 1'b1;
                end else if (t_off == etc_pkg::OFF_TMR_CMP) begin
                    tmr_rd[n] = tmr_stat[n].comparator;
                end
            end
        end
    end

    // ---------------- global state ----------------
    always_comb begin
        n_global = r_global;
        n_legacy = r_legacy;
        n_count  = r_count;
        n_status = r_status | tmr_match;
        if (is_write && sel_config) begin
            n_global = i_write_data[0];
            n_legacy = i_write_data[1];
        end
        if (is_write && sel_status) begin
            n_status = r_status & ~i_write_data[NT-1:0];
        end
        if (is_write && sel_counter) begin
            n_count = i_write_data;
        end else if (tick_en) begin
            n_count = count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global <= 1'b0;
            r_legacy <= 1'b0;
            r_count  <= '0;
            r_status <= '0;
        end else begin
            r_global <= n_global;
            r_legacy <= n_legacy;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    // ---------------- result ----------------
    always_comb begin
        caps        = '0;
        caps[7:0]   = r_revision;
        caps[12:8]  = 5'(NT - 1);
        caps[13]    = 1'b1;
        caps[15]    = 1'b1;
        caps[32 +: etc_pkg::PERIOD_FS_W] = r_period_fs;

        rd = '0;
        if (sel_caps) begin
            rd = caps;
        end else if (sel_config) begin
            rd[0] = r_global;
            rd[1] = r_legacy;
        end else if (sel_status) begin
            rd[NT-1:0] = r_status;
        end else if (sel_counter) begin
            rd = r_count;
        end else begin
            for (int k = 0; k < NT; k++) begin
                rd = rd | tmr_rd[k];
            end
        end

        lines = n_global ? (n_status & int_en_nx) : '0;

        res.read_data   = is_read ? rd : '0;
        res.legacy_irq0 = 1'b0;
        res.legacy_irq8 = 1'b0;
        if (n_legacy) begin
            res.legacy_irq0 = lines[0];
            res.legacy_irq8 = lines[1];
            lines[1:0]      = 2'b00;
        end
        res.timer_irq = lines;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out.read_data;
    assign o_timer_irq   = r_out.timer_irq;
    assign o_legacy_irq0 = r_out.legacy_irq0;
    assign o_legacy_irq8 = r_out.legacy_irq8;

endmodule
